>>> rtl/core/gshr_pkg.sv
// Shared types, constants and a counter helper for the gshare branch predictor.
package gshr_pkg;

    localparam int HIST_W_DEF       = 10;
    localparam int PC_W             = 32;
    localparam int HIST_OUT_W       = 16;
    localparam int CTR_W            = 2;

    localparam logic [CTR_W-1:0] CTR_RESET     = 2'b01;
    localparam logic [CTR_W-1:0] CTR_MIN       = 2'd0;
    localparam logic [CTR_W-1:0] CTR_MAX       = 2'd3;
    localparam logic [CTR_W-1:0] CTR_TAKEN_MIN = 2'd2;

    typedef enum logic {
        CMD_PREDICT = 1'b0,
        CMD_UPDATE  = 1'b1
    } t_cmd;

    typedef struct packed {
        t_cmd            command;
        logic [PC_W-1:0] pc;
        logic            taken;
    } t_in_beat;

    typedef struct packed {
        logic                  predict_taken;
        logic                  mispredicted;
        logic [HIST_OUT_W-1:0] history_now;
    } t_out_beat;

    // Move a saturating counter one step toward the resolved outcome.
    function automatic logic [CTR_W-1:0] ctr_step(logic [CTR_W-1:0] ctr, logic taken);
        logic [CTR_W-1:0] res;
        res = ctr;
        if (taken && (ctr != CTR_MAX)) begin
            res = ctr + 2'd1;
        end else if (!taken && (ctr != CTR_MIN)) begin
            res = ctr - 2'd1;
        end
        return res;
    endfunction

endpackage

>>> rtl/core/gshr_pht.sv
// Pattern history table: one synchronous counter memory with a clearing sweep after reset.
module gshr_pht import gshr_pkg::*; #(
    parameter int HIST_W = HIST_W_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [HIST_W-1:0] i_rd_idx,
    output logic [CTR_W-1:0]  o_rd_ctr,
    input  logic              i_wr_en,
    input  logic [HIST_W-1:0] i_wr_idx,
    input  logic [CTR_W-1:0]  i_wr_ctr,
    output logic              o_clearing
);

    localparam int Depth = 1 << HIST_W;

    logic [CTR_W-1:0]  r_mem [Depth];
    logic [CTR_W-1:0]  r_rd_ctr;
    logic              r_clearing;
    logic [HIST_W-1:0] r_clr_idx;

    // After reset every entry is rewritten to weakly not taken, one per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clearing) begin
            r_clr_idx <= r_clr_idx + HIST_W'(1);
            if (&r_clr_idx) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_idx] <= CTR_RESET;
        end else if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_ctr;
        end
        if (i_rd_en) begin
            r_rd_ctr <= r_mem[i_rd_idx];
        end
    end

    assign o_rd_ctr   = r_rd_ctr;
    assign o_clearing = r_clearing;

endmodule

>>> rtl/core/gshr_stage.sv
// Read-data stage: forwards the previous write, forms the prediction and writes the counter back.
module gshr_stage import gshr_pkg::*; #(
    parameter int HIST_W = HIST_W_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_acc,
    input  t_cmd              i_cmd,
    input  logic              i_taken,
    input  logic [HIST_W-1:0] i_idx,
    input  logic [HIST_W-1:0] i_hist,
    input  logic [CTR_W-1:0]  i_rd_ctr,
    output logic              o_wr_en,
    output logic [HIST_W-1:0] o_wr_idx,
    output logic [CTR_W-1:0]  o_wr_ctr,
    output logic              o_res_valid,
    output t_out_beat         o_res
);

    logic              r_valid;
    t_cmd              r_cmd;
    logic              r_taken;
    logic [HIST_W-1:0] r_idx;
    logic [HIST_W-1:0] r_hist;

    logic              r_fwd_valid;
    logic [HIST_W-1:0] r_fwd_idx;
    logic [CTR_W-1:0]  r_fwd_ctr;

    logic [CTR_W-1:0] ctr;
    logic             pred;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_fwd_valid <= 1'b0;
        end else begin
            r_valid     <= i_acc;
            r_fwd_valid <= o_wr_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_cmd   <= i_cmd;
            r_taken <= i_taken;
            r_idx   <= i_idx;
            r_hist  <= i_hist;
        end
        r_fwd_idx <= o_wr_idx;
        r_fwd_ctr <= o_wr_ctr;
    end

    // The memory read issued in the cycle of the last write returns stale data.
    always_comb begin
        if (r_fwd_valid && (r_fwd_idx == r_idx)) begin
            ctr = r_fwd_ctr;
        end else begin
            ctr = i_rd_ctr;
        end
        pred = (ctr >= CTR_TAKEN_MIN);
    end

    assign o_wr_en  = r_valid && (r_cmd == CMD_UPDATE);
    assign o_wr_idx = r_idx;
    assign o_wr_ctr = ctr_step(ctr, r_taken);

    assign o_res_valid         = r_valid;
    assign o_res.predict_taken = pred;
    assign o_res.mispredicted  = (r_cmd == CMD_UPDATE) && (pred != r_taken);
    assign o_res.history_now   = HIST_OUT_W'(r_hist);

endmodule

>>> rtl/core/gshr_outq.sv
// Two-entry result queue that decouples the pipeline from the output handshake.
module gshr_outq import gshr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_out_beat i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_beat o_data,
    output logic [1:0] o_count
);

    t_out_beat  r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic       pop;

    assign pop = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (pop) begin
                r_rptr <= ~r_rptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rptr];
    assign o_count = r_count;

endmodule

>>> rtl/core/gshare_branch_predictor.sv
// Top level of the gshare branch predictor with 2-bit saturating counters.
//
//   channel  | direction | handshake                 | payload
//   ---------+-----------+---------------------------+------------------------------
//   in       | to block  | i_in_valid / o_in_ready   | i_in_beat  (command, pc, taken)
//   out      | from block| o_out_valid / i_out_ready | o_out_beat (predict_taken,
//            |           |                           |   mispredicted, history_now)
//
// One beat is accepted per cycle while the consumer keeps up; its result passes
// through the read-data stage behind the counter memory and the result queue
// register before it is offered on the output.
// After reset the counter memory is swept to weakly not taken, one entry per cycle,
// so no beat is accepted until all 2**HIST_W entries (1024 by default) are cleared.
// Apart from that sweep, input acceptance stops only when two results are already
// waiting or in flight and none is being taken in the same cycle.
module gshare_branch_predictor import gshr_pkg::*; #(
    parameter int HIST_W = HIST_W_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in_beat,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_beat
);

    logic [HIST_W-1:0] r_hist;
    logic [HIST_W-1:0] n_hist;
    logic [HIST_W-1:0] idx;
    logic              acc;
    logic              clearing;

    logic [CTR_W-1:0]  rd_ctr;
    logic              wr_en;
    logic [HIST_W-1:0] wr_idx;
    logic [CTR_W-1:0]  wr_ctr;

    logic              res_valid;
    t_out_beat         res;
    logic [1:0]        q_count;
    logic [1:0]        pending;
    logic              pop;

    // Index uses the history as it stands before this beat's own update.
    assign idx = i_in_beat.pc[HIST_W+1:2] ^ r_hist;

    // Beats held in the read stage or the queue may not exceed the queue depth.
    assign pop        = o_out_valid && i_out_ready;
    assign pending    = q_count + {1'b0, res_valid} - {1'b0, pop};
    assign o_in_ready = !clearing && (pending < 2'd2);
    assign acc        = i_in_valid && o_in_ready;

    // The history depends only on the input beat, so it advances at acceptance.
    always_comb begin
        n_hist = r_hist;
        if (acc && (i_in_beat.command == CMD_UPDATE)) begin
            n_hist = HIST_W'({r_hist, i_in_beat.taken});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '0;
        end else begin
            r_hist <= n_hist;
        end
    end

    gshr_pht #(
        .HIST_W(HIST_W)
    ) u_pht (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (acc),
        .i_rd_idx   (idx),
        .o_rd_ctr   (rd_ctr),
        .i_wr_en    (wr_en),
        .i_wr_idx   (wr_idx),
        .i_wr_ctr   (wr_ctr),
        .o_clearing (clearing)
    );

    gshr_stage #(
        .HIST_W(HIST_W)
    ) u_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_acc       (acc),
        .i_cmd       (i_in_beat.command),
        .i_taken     (i_in_beat.taken),
        .i_idx       (idx),
        .i_hist      (n_hist),
        .i_rd_ctr    (rd_ctr),
        .o_wr_en     (wr_en),
        .o_wr_idx    (wr_idx),
        .o_wr_ctr    (wr_ctr),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    gshr_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_beat),
        .o_count (q_count)
    );

endmodule
